/* rtl/core/fffl_pkg.sv */
// Shared constants, codes and payload types of the first-fit free-list allocator.
package fffl_pkg;

  localparam int POOL_UNITS = 4096;
  localparam int UNIT_BYTES = 8;
  localparam int IDX_W      = 12;
  localparam int SZ_W       = 13;
  localparam int BYTES_W    = 16;
  localparam int WANT_W     = 14;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [BYTES_W-1:0] request_bytes;
    logic [IDX_W-1:0]   release_index;
  } fffl_req_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] block_index;
  } fffl_rsp_t;

endpackage

/* rtl/core/fffl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module fffl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/first_fit_free_list_allocator.sv */
// Top level of the first-fit free-list allocator with coalescing.
//
// Request handshake: a transfer is taken when start_i is high and busy_o low. Each
// request produces exactly one response, shown on rsp_o for one cycle with
// rsp_valid_o high; the receiver cannot stall it. The free list lives in two
// RAMs (link and size, one read and one write port each, registered read
// data), and every list step costs one RAM read. An allocate is answered from
// idle, without a walk, when the list is empty or the free count already rules
// it out. A carve from the tail keeps busy_o high while its response is shown,
// as S_A_TAIL writes the tail header; an exact fit does not. A release is
// answered from idle for index zero, from S_R_BSZ when the list is empty or the
// block header is bad, and from S_R_NXT when the block joins the only free
// block, which lies directly above it. Walks are bounded at POOL_UNITS + 1
// steps, so a corrupted list ends in a no-space answer or an ignored release.
// Release handles are assumed valid. No RAM clearing pass is needed: entry 0
// of each store carries a valid bit that supplies its reset value until first
// written.
module first_fit_free_list_allocator
  import fffl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  fffl_req_t req_i,
  output logic      busy_o,
  output logic      rsp_valid_o,
  output fffl_rsp_t rsp_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_A_LINK = 8'b0000_0010,
    S_A_SIZE = 8'b0000_0100,
    S_A_TAIL = 8'b0000_1000,
    S_R_BSZ  = 8'b0001_0000,
    S_R_WALK = 8'b0010_0000,
    S_R_NXT  = 8'b0100_0000,
    S_R_CUR  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  rover_q, rover_d;
  logic [SZ_W-1:0]   free_q, free_d;
  logic              empty_q, empty_d;
  logic [SZ_W-1:0]   steps_q, steps_d;
  logic [WANT_W-1:0] want_q, want_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  blk_q, blk_d;
  logic [SZ_W-1:0]   bsz_q, bsz_d;
  logic [IDX_W-1:0]  nxt_q, nxt_d;
  logic [IDX_W-1:0]  blk_link_q, blk_link_d;
  logic [SZ_W-1:0]   blk_size_q, blk_size_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic              rsp_valid_q, rsp_valid_d;
  fffl_rsp_t         rsp_q, rsp_d;

  // Valid bits for entry 0 of each store (reset value until first written)
  logic link_v0_q, size_v0_q;
  logic [IDX_W-1:0] link_ra_q, size_ra_q;

  logic             link_we, size_we;
  logic [IDX_W-1:0] link_wa, size_wa, link_ra, size_ra;
  logic [IDX_W-1:0] link_wd, link_ram_rd, link_rd;
  logic [SZ_W-1:0]  size_wd, size_ram_rd, size_rd;

  fffl_ram #(.Width(IDX_W), .Depth(POOL_UNITS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .raddr_i (link_ra),
    .rdata_o (link_ram_rd)
  );

  fffl_ram #(.Width(SZ_W), .Depth(POOL_UNITS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_wa),
    .wdata_i (size_wd),
    .raddr_i (size_ra),
    .rdata_o (size_ram_rd)
  );

  assign link_rd = (link_ra_q == '0 && !link_v0_q) ? '0 : link_ram_rd;
  assign size_rd = (size_ra_q == '0 && !size_v0_q) ? SZ_W'(POOL_UNITS) : size_ram_rd;

  // Request decode: round bytes up to units, add the header unit
  logic [BYTES_W:0]  bytes_eff;
  logic [WANT_W-1:0] want_req;
  assign bytes_eff = (req_i.request_bytes == '0) ? (BYTES_W+1)'(1)
                                                 : {1'b0, req_i.request_bytes};
  assign want_req  = WANT_W'(1) + WANT_W'((bytes_eff + (BYTES_W+1)'(UNIT_BYTES - 1))
                                          / UNIT_BYTES);

  // Walk datapath helpers
  logic [WANT_W-1:0] tail_w, blk_end, cur_end;
  logic              found;
  logic [WANT_W-1:0] free_sum;

  assign tail_w   = WANT_W'(cur_q) + (WANT_W'(size_rd) - want_q);
  assign blk_end  = WANT_W'(blk_q) + WANT_W'(bsz_q);
  assign cur_end  = WANT_W'(cur_q) + WANT_W'(size_rd);
  assign found    = (blk_q > cur_q && blk_q < link_rd) ||
                    (cur_q >= link_rd && (blk_q > cur_q || blk_q < link_rd));
  assign free_sum = WANT_W'(free_q) + WANT_W'(bsz_q);

  always_comb begin
    state_d     = state_q;
    rover_d     = rover_q;
    free_d      = free_q;
    empty_d     = empty_q;
    steps_d     = steps_q;
    want_d      = want_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    blk_d       = blk_q;
    bsz_d       = bsz_q;
    nxt_d       = nxt_q;
    blk_link_d  = blk_link_q;
    blk_size_d  = blk_size_q;
    tail_d      = tail_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    link_we     = 1'b0;
    link_wa     = '0;
    link_wd     = '0;
    size_we     = 1'b0;
    size_wa     = '0;
    size_wd     = '0;
    link_ra     = '0;
    size_ra     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (req_i.func == FUNC_ALLOC) begin
            want_d = want_req;
            if (empty_q || WANT_W'(free_q) < want_req) begin
              rsp_valid_d       = 1'b1;
              rsp_d.status      = STATUS_NOSPACE;
              rsp_d.block_index = '0;
            end else begin
              prev_d  = rover_q;
              link_ra = rover_q;
              state_d = S_A_LINK;
            end
          end else begin
            if (req_i.release_index == '0 ||
                {1'b0, req_i.release_index} >= SZ_W'(POOL_UNITS)) begin
              rsp_valid_d       = 1'b1;
              rsp_d.status      = STATUS_DONE;
              rsp_d.block_index = '0;
            end else begin
              blk_d   = req_i.release_index - IDX_W'(1);
              size_ra = req_i.release_index - IDX_W'(1);
              state_d = S_R_BSZ;
            end
          end
        end
      end

      S_A_LINK: begin
        cur_d   = link_rd;
        steps_d = '0;
        size_ra = link_rd;
        link_ra = link_rd;
        state_d = S_A_SIZE;
      end

      S_A_SIZE: begin
        priority if (WANT_W'(size_rd) == want_q) begin
          // exact fit: unlink the block, or empty the list
          if (cur_q == prev_q) begin
            empty_d = 1'b1;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q;
            link_wd = link_rd;
          end
          rover_d           = prev_q;
          free_d            = free_q - SZ_W'(want_q);
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_DONE;
          rsp_d.block_index = cur_q + IDX_W'(1);
          state_d           = S_IDLE;
        end else if (WANT_W'(size_rd) > want_q &&
                     tail_w + WANT_W'(1) < WANT_W'(POOL_UNITS)) begin
          // carve from the tail; the tail header is written next cycle
          size_we           = 1'b1;
          size_wa           = cur_q;
          size_wd           = SZ_W'(WANT_W'(size_rd) - want_q);
          tail_d            = IDX_W'(tail_w);
          rover_d           = prev_q;
          free_d            = free_q - SZ_W'(want_q);
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_DONE;
          rsp_d.block_index = IDX_W'(tail_w + WANT_W'(1));
          state_d           = S_A_TAIL;
        end else if (cur_q == rover_q || steps_q == SZ_W'(POOL_UNITS)) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_NOSPACE;
          rsp_d.block_index = '0;
          state_d           = S_IDLE;
        end else begin
          // advance one entry
          steps_d = steps_q + SZ_W'(1);
          prev_d  = cur_q;
          cur_d   = link_rd;
          size_ra = link_rd;
          link_ra = link_rd;
        end
      end

      S_A_TAIL: begin
        size_we = 1'b1;
        size_wa = tail_q;
        size_wd = SZ_W'(want_q);
        state_d = S_IDLE;
      end

      S_R_BSZ: begin
        bsz_d = size_rd;
        if (size_rd == '0 ||
            WANT_W'(blk_q) + WANT_W'(size_rd) > WANT_W'(POOL_UNITS)) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_DONE;
          rsp_d.block_index = '0;
          state_d           = S_IDLE;
        end else if (empty_q) begin
          link_we           = 1'b1;
          link_wa           = blk_q;
          link_wd           = blk_q;
          rover_d           = blk_q;
          empty_d           = 1'b0;
          free_d            = (WANT_W'(size_rd) > WANT_W'(POOL_UNITS)) ?
                              SZ_W'(POOL_UNITS) : size_rd;
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_DONE;
          rsp_d.block_index = '0;
          state_d           = S_IDLE;
        end else begin
          cur_d   = rover_q;
          steps_d = '0;
          link_ra = rover_q;
          state_d = S_R_WALK;
        end
      end

      S_R_WALK: begin
        priority if (found) begin
          free_d  = (free_sum > WANT_W'(POOL_UNITS)) ? SZ_W'(POOL_UNITS)
                                                     : SZ_W'(free_sum);
          nxt_d   = link_rd;
          size_ra = link_rd;
          link_ra = link_rd;
          state_d = S_R_NXT;
        end else if (steps_q == SZ_W'(POOL_UNITS)) begin
          // drop the release: no insertion point on a corrupted list
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STATUS_DONE;
          rsp_d.block_index = '0;
          state_d           = S_IDLE;
        end else begin
          steps_d = steps_q + SZ_W'(1);
          cur_d   = link_rd;
          link_ra = link_rd;
        end
      end

      S_R_NXT: begin
        size_ra = cur_q;
        state_d = S_R_CUR;
        if (blk_end == WANT_W'(nxt_q)) begin
          // join with the upper neighbour
          size_we    = 1'b1;
          size_wa    = blk_q;
          size_wd    = bsz_q + size_rd;
          blk_size_d = bsz_q + size_rd;
          link_we    = 1'b1;
          link_wa    = blk_q;
          if (nxt_q == cur_q) begin
            link_wd           = blk_q;
            rover_d           = blk_q;
            rsp_valid_d       = 1'b1;
            rsp_d.status      = STATUS_DONE;
            rsp_d.block_index = '0;
            state_d           = S_IDLE;
          end else begin
            link_wd    = link_rd;
            blk_link_d = link_rd;
          end
        end else begin
          link_we    = 1'b1;
          link_wa    = blk_q;
          link_wd    = nxt_q;
          blk_link_d = nxt_q;
          blk_size_d = bsz_q;
        end
      end

      S_R_CUR: begin
        link_we = 1'b1;
        link_wa = cur_q;
        if (cur_end == WANT_W'(blk_q)) begin
          // join with the lower neighbour
          size_we = 1'b1;
          size_wa = cur_q;
          size_wd = size_rd + blk_size_q;
          link_wd = blk_link_q;
        end else begin
          link_wd = blk_q;
        end
        rover_d           = cur_q;
        rsp_valid_d       = 1'b1;
        rsp_d.status      = STATUS_DONE;
        rsp_d.block_index = '0;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rover_q     <= '0;
      free_q      <= SZ_W'(POOL_UNITS);
      empty_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
      link_v0_q   <= 1'b0;
      size_v0_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      free_q      <= free_d;
      empty_q     <= empty_d;
      rsp_valid_q <= rsp_valid_d;
      if (link_we && link_wa == '0) begin
        link_v0_q <= 1'b1;
      end
      if (size_we && size_wa == '0) begin
        size_v0_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    want_q     <= want_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    blk_q      <= blk_d;
    bsz_q      <= bsz_d;
    nxt_q      <= nxt_d;
    blk_link_q <= blk_link_d;
    blk_size_q <= blk_size_d;
    tail_q     <= tail_d;
    rsp_q      <= rsp_d;
    link_ra_q  <= link_ra;
    size_ra_q  <= size_ra;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_fail_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status == STATUS_NOSPACE |-> rsp_o.block_index == '0)
    else $error("no-space response carries a block index");

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= SZ_W'(POOL_UNITS))
    else $error("free unit count exceeds the pool");

  a_release_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.func == FUNC_RELEASE && req_i.release_index != '0
    |=> !rsp_valid_o)
    else $error("release answered before its size was read");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_A_TAIL |-> $past(rsp_valid_d))
    else $error("tail write without a carve response");
`endif

endmodule
